// ----- sv/mmrc_pkg.sv -----
// shared types, codes and helper functions of the memory map region converter
`default_nettype none

package mmrc_pkg;

	// address and length widths
	localparam int ADDR_W = 52;
	localparam int LEN_W = 53;
	localparam int PAGES_W = 40;
	localparam int FWTYPE_W = 32;
	localparam int PAGE_SHIFT = 12;

	// depth of the queues between the parts
	localparam int QUEUE_DEPTH = 2;

	// reset value of both kernel window bounds
	localparam logic [ADDR_W-1:0] KERNEL_RESET = 52'h0_0000_0010_0000;

	// firmware memory type codes that matter here
	localparam logic [FWTYPE_W-1:0] FW_LOADER_CODE = 32'd1;
	localparam logic [FWTYPE_W-1:0] FW_LOADER_DATA = 32'd2;
	localparam logic [FWTYPE_W-1:0] FW_BOOT_CODE = 32'd3;
	localparam logic [FWTYPE_W-1:0] FW_BOOT_DATA = 32'd4;
	localparam logic [FWTYPE_W-1:0] FW_CONVENTIONAL = 32'd7;
	localparam logic [FWTYPE_W-1:0] FW_UNUSABLE = 32'd8;
	localparam logic [FWTYPE_W-1:0] FW_ACPI_RECLAIM = 32'd9;
	localparam logic [FWTYPE_W-1:0] FW_ACPI_NVS = 32'd10;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_AVAILABLE = 3'd1,
		KIND_RESERVED = 3'd2,
		KIND_ACPI = 3'd3,
		KIND_NVS = 3'd4,
		KIND_BAD = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ACT_DROP = 2'd0,
		ACT_NEW = 2'd1,
		ACT_EXTEND = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		CFG_KERNEL_LOW = 3'd0,
		CFG_KERNEL_HIGH = 3'd1,
		CFG_HANDOFF_LOW = 3'd2,
		CFG_HANDOFF_HIGH = 3'd3,
		CFG_MODULE_LOW = 3'd4,
		CFG_MODULE_HIGH = 3'd5
	} cfg_idx_t;

	// one register write beat
	typedef struct packed {
		logic valid;
		logic [2:0] index;
		logic [ADDR_W-1:0] data;
	} cfg_wr_t;

	// classified descriptor handed from front to back
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0] len;
		kind_t kind;
		logic first;
		logic last;
	} item_t;

	// one result beat
	typedef struct packed {
		action_t action;
		logic [6:0] index;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0] len;
		kind_t kind;
		logic [7:0] total;
		logic done;
	} result_t;

	// firmware type code to table kind
	function automatic kind_t kind_of(input logic [FWTYPE_W-1:0] code);
		kind_t k;
		case (code)
			FW_LOADER_CODE, FW_LOADER_DATA, FW_BOOT_CODE, FW_BOOT_DATA,
			FW_CONVENTIONAL: k = KIND_AVAILABLE;
			FW_ACPI_RECLAIM: k = KIND_ACPI;
			FW_ACPI_NVS: k = KIND_NVS;
			FW_UNUSABLE: k = KIND_BAD;
			default: k = KIND_RESERVED;
		endcase
		return k;
	endfunction

	// region [s, end) touches window [lo, hi)
	function automatic logic touches(input logic [ADDR_W-1:0] s,
			input logic [LEN_W-1:0] region_end, input logic [ADDR_W-1:0] lo,
			input logic [ADDR_W-1:0] hi);
		return (s < hi) && ({1'b0, lo} < region_end);
	endfunction

endpackage

`default_nettype wire

// ----- sv/memory_map_region_converter.sv -----
// top level of the memory map region converter
// path: front stage register, middle queue, merge stage, result queue, output ports
// throughput: one descriptor per cycle while results are popped; front stage, merge stage
// and output queue all keep pace, the merge loop closing on the registered end of the last entry
// reset: arst_n clears the entry count, last entry and queues; window registers take
// their reset values (kernel window at 1 MiB, others zero)
`default_nettype none

module memory_map_region_converter #(
	parameter int MAX_ENTRIES = 128
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [mmrc_pkg::ADDR_W-1:0] cfg_data,
	input wire logic push,
	output logic full,
	input wire logic [mmrc_pkg::ADDR_W-1:0] region_start,
	input wire logic [mmrc_pkg::PAGES_W-1:0] page_count,
	input wire logic [mmrc_pkg::FWTYPE_W-1:0] firmware_type,
	input wire logic first_descriptor,
	input wire logic last_descriptor,
	output logic empty,
	input wire logic pop,
	output logic [1:0] entry_action,
	output logic [6:0] entry_index,
	output logic [mmrc_pkg::ADDR_W-1:0] entry_addr,
	output logic [mmrc_pkg::LEN_W-1:0] entry_len,
	output logic [2:0] entry_kind,
	output logic [7:0] entry_total,
	output logic map_done
);

	localparam int ITEM_W = $bits(mmrc_pkg::item_t);
	localparam int RES_W = $bits(mmrc_pkg::result_t);

	mmrc_pkg::cfg_wr_t cfg;
	logic front_push;
	mmrc_pkg::item_t front_item;
	logic mid_full;
	logic mid_empty;
	logic mid_pop;
	logic [ITEM_W-1:0] mid_rdata;
	mmrc_pkg::item_t mid_item;
	logic out_full;
	logic out_push;
	mmrc_pkg::result_t back_res;
	logic [RES_W-1:0] out_rdata;
	mmrc_pkg::result_t head_res;

	// register write beat
	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data = cfg_data;

	mmrc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.push(push),
		.full(full),
		.region_start(region_start),
		.page_count(page_count),
		.firmware_type(firmware_type),
		.first_descriptor(first_descriptor),
		.last_descriptor(last_descriptor),
		.mid_push(front_push),
		.mid_item(front_item),
		.mid_full(mid_full)
	);

	// queue between front and back
	mmrc_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(mmrc_pkg::QUEUE_DEPTH)
	) u_mid_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(front_push),
		.wdata(front_item),
		.full(mid_full),
		.pop(mid_pop),
		.rdata(mid_rdata),
		.empty(mid_empty)
	);

	assign mid_item = mmrc_pkg::item_t'(mid_rdata);

	mmrc_back #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.mid_empty(mid_empty),
		.mid_item(mid_item),
		.mid_pop(mid_pop),
		.out_full(out_full),
		.out_push(out_push),
		.out_res(back_res)
	);

	// result queue
	mmrc_fifo #(
		.WIDTH(RES_W),
		.DEPTH(mmrc_pkg::QUEUE_DEPTH)
	) u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(out_push),
		.wdata(back_res),
		.full(out_full),
		.pop(pop),
		.rdata(out_rdata),
		.empty(empty)
	);

	// result fields
	assign head_res = mmrc_pkg::result_t'(out_rdata);
	assign entry_action = head_res.action;
	assign entry_index = head_res.index;
	assign entry_addr = head_res.addr;
	assign entry_len = head_res.len;
	assign entry_kind = head_res.kind;
	assign entry_total = head_res.total;
	assign map_done = head_res.done;

endmodule

`default_nettype wire

// ----- sv/mmrc_fifo.sv -----
// small first-in first-out queue of packed beats
`default_nettype none

module mmrc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [WIDTH-1:0] wdata,
	output logic full,
	input wire logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	// status and head beat
	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/mmrc_front.sv -----
// front part: window registers, type mapping and window checks
`default_nettype none

module mmrc_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire mmrc_pkg::cfg_wr_t cfg,
	input wire logic push,
	output logic full,
	input wire logic [mmrc_pkg::ADDR_W-1:0] region_start,
	input wire logic [mmrc_pkg::PAGES_W-1:0] page_count,
	input wire logic [mmrc_pkg::FWTYPE_W-1:0] firmware_type,
	input wire logic first_descriptor,
	input wire logic last_descriptor,
	output logic mid_push,
	output mmrc_pkg::item_t mid_item,
	input wire logic mid_full
);

	logic [mmrc_pkg::ADDR_W-1:0] kernel_low_q, kernel_high_q;
	logic [mmrc_pkg::ADDR_W-1:0] handoff_low_q, handoff_high_q;
	logic [mmrc_pkg::ADDR_W-1:0] module_low_q, module_high_q;

	logic valid_s1;
	mmrc_pkg::item_t item_s1;
	mmrc_pkg::item_t item_d;
	logic [mmrc_pkg::LEN_W-1:0] region_end;
	logic hit;
	logic advance;
	logic accept;
	mmrc_pkg::kind_t raw_kind;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_low_q <= mmrc_pkg::KERNEL_RESET;
			kernel_high_q <= mmrc_pkg::KERNEL_RESET;
			handoff_low_q <= '0;
			handoff_high_q <= '0;
			module_low_q <= '0;
			module_high_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				mmrc_pkg::CFG_KERNEL_LOW: kernel_low_q <= cfg.data;
				mmrc_pkg::CFG_KERNEL_HIGH: kernel_high_q <= cfg.data;
				mmrc_pkg::CFG_HANDOFF_LOW: handoff_low_q <= cfg.data;
				mmrc_pkg::CFG_HANDOFF_HIGH: handoff_high_q <= cfg.data;
				mmrc_pkg::CFG_MODULE_LOW: module_low_q <= cfg.data;
				mmrc_pkg::CFG_MODULE_HIGH: module_high_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// stage handshake
	assign advance = !valid_s1 || !mid_full;
	assign full = !advance;
	assign accept = push && advance;
	assign mid_push = valid_s1;
	assign mid_item = item_s1;

	// classify the incoming descriptor
	always_comb begin
		item_d.start = region_start;
		item_d.len = {1'b0, page_count, {mmrc_pkg::PAGE_SHIFT{1'b0}}};
		item_d.first = first_descriptor;
		item_d.last = last_descriptor;
		region_end = {1'b0, region_start} + item_d.len;
		raw_kind = mmrc_pkg::kind_of(firmware_type);
		hit = mmrc_pkg::touches(region_start, region_end, kernel_low_q, kernel_high_q)
			|| mmrc_pkg::touches(region_start, region_end, handoff_low_q, handoff_high_q)
			|| ((module_high_q != '0)
			&& mmrc_pkg::touches(region_start, region_end, module_low_q, module_high_q));
		if (raw_kind == mmrc_pkg::KIND_AVAILABLE && hit) begin
			item_d.kind = mmrc_pkg::KIND_RESERVED;
		end else begin
			item_d.kind = raw_kind;
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/mmrc_back.sv -----
// back part: merge with the last entry and count table entries
`default_nettype none

module mmrc_back #(
	parameter int MAX_ENTRIES = 128
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic mid_empty,
	input wire mmrc_pkg::item_t mid_item,
	output logic mid_pop,
	input wire logic out_full,
	output logic out_push,
	output mmrc_pkg::result_t out_res
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	logic [mmrc_pkg::ADDR_W-1:0] prev_addr_q;
	logic [mmrc_pkg::LEN_W-1:0] prev_len_q;
	logic [mmrc_pkg::LEN_W-1:0] prev_end_q;
	mmrc_pkg::kind_t prev_kind_q;
	logic [CW-1:0] count_q;

	logic [CW-1:0] count_eff;
	logic [CW-1:0] count_d;
	logic [CW-1:0] idx;
	logic [CW+6:0] idx_ext;
	logic [CW+7:0] total_ext;
	logic take;
	logic do_merge;
	logic do_new;
	logic [mmrc_pkg::ADDR_W-1:0] addr_d;
	logic [mmrc_pkg::LEN_W-1:0] len_d;
	logic [mmrc_pkg::LEN_W-1:0] end_d;
	mmrc_pkg::kind_t kind_d;

	assign take = !mid_empty && !out_full;
	assign mid_pop = take;
	assign out_push = take;

	// merge or open decision
	always_comb begin
		count_eff = mid_item.first ? '0 : count_q;
		do_merge = 1'b0;
		do_new = 1'b0;
		if (mid_item.len != '0 && count_eff < CW'(MAX_ENTRIES)) begin
			if (count_eff != '0 && prev_kind_q == mid_item.kind
					&& prev_end_q == {1'b0, mid_item.start}) begin
				do_merge = 1'b1;
			end else begin
				do_new = 1'b1;
			end
		end
		addr_d = prev_addr_q;
		len_d = prev_len_q;
		end_d = prev_end_q;
		kind_d = prev_kind_q;
		count_d = count_eff;
		idx = count_eff;
		if (do_merge) begin
			len_d = prev_len_q + mid_item.len;
			end_d = prev_end_q + mid_item.len;
			idx = count_eff - 1'b1;
		end else if (do_new) begin
			addr_d = mid_item.start;
			len_d = mid_item.len;
			end_d = {1'b0, mid_item.start} + mid_item.len;
			kind_d = mid_item.kind;
			count_d = count_eff + 1'b1;
		end
		idx_ext = {7'd0, idx};
		total_ext = {8'd0, count_d};
	end

	// result beat
	always_comb begin
		out_res.total = total_ext[7:0];
		out_res.done = mid_item.last;
		if (do_merge || do_new) begin
			out_res.action = do_merge ? mmrc_pkg::ACT_EXTEND : mmrc_pkg::ACT_NEW;
			out_res.index = idx_ext[6:0];
			out_res.addr = addr_d;
			out_res.len = len_d;
			out_res.kind = kind_d;
		end else begin
			out_res.action = mmrc_pkg::ACT_DROP;
			out_res.index = '0;
			out_res.addr = '0;
			out_res.len = '0;
			out_res.kind = mmrc_pkg::KIND_NONE;
		end
	end

	// last entry and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_addr_q <= '0;
			prev_len_q <= '0;
			prev_end_q <= '0;
			prev_kind_q <= mmrc_pkg::KIND_NONE;
			count_q <= '0;
		end else if (take) begin
			prev_addr_q <= addr_d;
			prev_len_q <= len_d;
			prev_end_q <= end_d;
			prev_kind_q <= kind_d;
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire
